// ----- rtl/sem_pkg.sv -----
// shared types, constants and helpers of the sobel edge magnitude unit
`default_nettype none
package sem_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int DimW      = 11;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int PixW      = 24;
    localparam int SqW       = 22;
    localparam int RootW     = 11;
    localparam int CfgIdxW   = 2;

    localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } root_ctl_t;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                  input logic [DimW-1:0] hi);
        logic [DimW-1:0] r;
        begin
            r = v;
            if (v < DimW'(2))
            begin
                r = DimW'(2);
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

    // squared magnitude of one channel from the eight neighbours of a 3x3 window
    function automatic logic [SqW-1:0] sobel_sq(input logic [7:0] p00, input logic [7:0] p01,
                                                input logic [7:0] p02, input logic [7:0] p10,
                                                input logic [7:0] p12, input logic [7:0] p20,
                                                input logic [7:0] p21, input logic [7:0] p22);
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic [21:0] ax;
        logic [21:0] ay;
        begin
            gx = ($signed({4'd0, p02}) - $signed({4'd0, p00}))
                 + 12'sd2 * ($signed({4'd0, p12}) - $signed({4'd0, p10}))
                 + ($signed({4'd0, p22}) - $signed({4'd0, p20}));
            gy = ($signed({4'd0, p20}) + 12'sd2 * $signed({4'd0, p21}) + $signed({4'd0, p22}))
                 - ($signed({4'd0, p00}) + 12'sd2 * $signed({4'd0, p01})
                 + $signed({4'd0, p02}));
            ax = 22'(gx < 0 ? -gx : gx);
            ay = 22'(gy < 0 ? -gy : gy);
            return SqW'(ax * ax) + SqW'(ay * ay);
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/sem_if.sv -----
// valid/ready channel interfaces of the sobel edge magnitude unit
`default_nettype none
interface sem_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface sem_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       last_of_run;
    logic       end_of_frame;
    modport source (output valid, red_edge, green_edge, blue_edge, last_of_run,
                    end_of_frame, input ready);
    modport sink (input valid, red_edge, green_edge, blue_edge, last_of_run,
                  end_of_frame, output ready);
endinterface

interface sem_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/sem_root.sv -----
// bit-serial restoring square root of three channels, one digit per cycle
`default_nettype none
module sem_root
    import sem_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [SqW-1:0]  sq_r,
    input  wire logic [SqW-1:0]  sq_g,
    input  wire logic [SqW-1:0]  sq_b,
    output root_ctl_t            ctl,
    output logic [7:0]           root_r,
    output logic [7:0]           root_g,
    output logic [7:0]           root_b
);
    logic [3:0]       step_reg;
    logic [3:0]       step_next;
    logic             busy_reg;
    logic             busy_next;
    logic [SqW-1:0]   rem_reg [3];
    logic [SqW-1:0]   rem_next [3];
    logic [SqW-1:0]   val_reg [3];
    logic [SqW-1:0]   val_next [3];
    logic [RootW-1:0] q_reg [3];
    logic [RootW-1:0] q_next [3];
    logic [SqW+1:0]   trial [3];

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        for (int i = 0; i < 3; i++)
        begin
            rem_next[i] = rem_reg[i];
            val_next[i] = val_reg[i];
            q_next[i]   = q_reg[i];
            trial[i]    = '0;
        end
        if (start)
        begin
            busy_next   = 1'b1;
            step_next   = 4'd0;
            val_next[0] = sq_r;
            val_next[1] = sq_g;
            val_next[2] = sq_b;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = '0;
                q_next[i]   = '0;
            end
        end
        else if (busy_reg)
        begin
            // shift in two radicand bits, try q*4+1
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {rem_reg[i], val_reg[i][SqW-1 -: 2]}
                           - {{(SqW-RootW-1){1'b0}}, q_reg[i], 2'b01};
                val_next[i] = {val_reg[i][SqW-3:0], 2'b00};
                if (!trial[i][SqW+1])
                begin
                    rem_next[i] = trial[i][SqW-1:0];
                    q_next[i]   = {q_reg[i][RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = SqW'({rem_reg[i], val_reg[i][SqW-1 -: 2]});
                    q_next[i]   = {q_reg[i][RootW-2:0], 1'b0};
                end
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(RootW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[i] <= rem_next[i];
            val_reg[i] <= val_next[i];
            q_reg[i]   <= q_next[i];
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = busy_reg && (step_reg == 4'(RootW - 1));
    assign root_r = (q_reg[0] > RootW'(255)) ? 8'hff : q_reg[0][7:0];
    assign root_g = (q_reg[1] > RootW'(255)) ? 8'hff : q_reg[1][7:0];
    assign root_b = (q_reg[2] > RootW'(255)) ? 8'hff : q_reg[2][7:0];

    a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("root restarted while busy");
    a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < 4'(RootW)) else $error("root step overrun");
    a_done_ends : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |=> !busy_reg) else $error("root busy after last digit");
endmodule
`default_nettype wire

// ----- rtl/sobel_edge_magnitude_unit.sv -----
// top level of the sobel edge magnitude unit: line stores, window, sequencer
//
//  channel | dir | handshake    | payload
//  pix     | in  | valid/ready  | red_in, green_in, blue_in
//  edge    | out | valid/ready  | red_edge, green_edge, blue_edge, last_of_run, end_of_frame
//  cfg     | in  | valid/ready  | index, data (frame_width, frame_height)
//
// a pixel gives none, one or two results; each result runs through the 11-digit
// shared square root unit, one digit per cycle for all three channels
// reset clears counters, window and pending flag; line store content is undefined
// the output register holds a result until taken; the next pixel may enter meanwhile,
// but a new result waits until the held one is taken
`default_nettype none
module sobel_edge_magnitude_unit
    import sem_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sem_pix_if.sink     pix,
    sem_edge_if.source  edge_out,
    sem_cfg_if.sink     cfg
);
    state_t            state_reg;
    state_t            state_next;
    logic [DimW-1:0]   width_reg;
    logic [DimW-1:0]   height_reg;
    logic [ColW-1:0]   col_reg;
    logic [RowW-1:0]   row_reg;
    logic              pending_reg;
    logic [PixW-1:0]   win_reg [3][3];
    logic [PixW-1:0]   lsa [MaxWidth];
    logic [PixW-1:0]   lsb [MaxWidth];
    logic [PixW-1:0]   rd_a_reg;
    logic [PixW-1:0]   rd_b_reg;
    logic [PixW-1:0]   px_reg;
    logic              ok_reg;
    logic [RowW-1:0]   crow_reg;
    logic [ColW-1:0]   c_reg;
    logic              rd_reg;
    logic              need1_reg;
    logic              need2_reg;
    logic              second_reg;
    logic [PixW-1:0]   ew [3][3];
    logic [SqW-1:0]    sq [3];
    logic              root_start;
    root_ctl_t         rctl;
    logic [7:0]        root_r;
    logic [7:0]        root_g;
    logic [7:0]        root_b;
    logic              ovalid_reg;
    logic [7:0]        ored_reg;
    logic [7:0]        ogrn_reg;
    logic [7:0]        oblu_reg;
    logic              olast_reg;
    logic              oeof_reg;
    logic [DimW-1:0]   wdim;
    logic [DimW-1:0]   hdim;
    logic [ColW-1:0]   wlast;
    logic [RowW-1:0]   hlast;
    logic              pix_acc;
    logic              cfg_acc;
    logic              root_wait_reg;
    logic              out_load;

    assign wdim  = clamp_dim(width_reg, DimW'(MaxWidth));
    assign hdim  = clamp_dim(height_reg, DimW'(MaxHeight));
    assign wlast = ColW'(wdim - DimW'(1));
    assign hlast = RowW'(hdim - DimW'(1));
    assign pix_acc = pix.valid && pix.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign pix.ready = (state_reg == ST_IDLE) && !rd_reg && !cfg.valid;
    assign cfg.ready = (state_reg == ST_IDLE) && !rd_reg && !ovalid_reg;
    assign out_load  = (state_reg == ST_OUT) && (!ovalid_reg || edge_out.ready);

    // line store reads, registered
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            rd_a_reg <= lsa[col_reg];
            rd_b_reg <= lsb[col_reg];
            lsa[col_reg] <= lsb[col_reg];
            lsb[col_reg] <= {pix.blue_in, pix.green_in, pix.red_in};
            px_reg <= {pix.blue_in, pix.green_in, pix.red_in};
        end
    end

    // window assembly for the result being computed
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!second_reg)
            begin
                ew[k][0] = (c_reg == ColW'(1)) ? '0 : win_reg[k][0];
                ew[k][1] = win_reg[k][1];
                ew[k][2] = win_reg[k][2];
            end
            else
            begin
                ew[k][0] = win_reg[k][1];
                ew[k][1] = win_reg[k][2];
                ew[k][2] = '0;
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            sq[ch] = sobel_sq(ew[0][0][8*ch +: 8], ew[0][1][8*ch +: 8], ew[0][2][8*ch +: 8],
                              ew[1][0][8*ch +: 8], ew[1][2][8*ch +: 8], ew[2][0][8*ch +: 8],
                              ew[2][1][8*ch +: 8], ew[2][2][8*ch +: 8]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rd_reg && (need1_reg || need2_reg))
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rctl.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || edge_out.ready)
                begin
                    state_next = (!second_reg && need2_reg) ? ST_ROOT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        root_start = 1'b0;
        case (state_reg)
            ST_ROOT: root_start = !rctl.busy && !root_wait_reg;
            default: root_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= DimW'(MaxWidth);
            height_reg    <= DimW'(MaxHeight);
            col_reg       <= '0;
            row_reg       <= '0;
            pending_reg   <= 1'b0;
            rd_reg        <= 1'b0;
            ovalid_reg    <= 1'b0;
            need1_reg     <= 1'b0;
            need2_reg     <= 1'b0;
            second_reg    <= 1'b0;
            ok_reg        <= 1'b0;
            root_wait_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (edge_out.ready && !out_load)
            begin
                ovalid_reg <= 1'b0;
            end
            if (cfg_acc && (cfg.index == CfgWidth || cfg.index == CfgHeight))
            begin
                if (cfg.index == CfgWidth)
                begin
                    width_reg <= cfg.data;
                end
                else
                begin
                    height_reg <= cfg.data;
                end
                col_reg     <= '0;
                row_reg     <= '0;
                pending_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        win_reg[i][j] <= '0;
                    end
                end
            end
            if (pix_acc)
            begin
                rd_reg   <= 1'b1;
                c_reg    <= col_reg;
                ok_reg   <= (row_reg != '0) || pending_reg;
                crow_reg <= (row_reg != '0) ? row_reg - RowW'(1) : hlast;
                need1_reg <= ((row_reg != '0) || pending_reg) && (col_reg != '0);
                need2_reg <= ((row_reg != '0) || pending_reg) && (col_reg == wlast);
                if ((row_reg == '0) && (col_reg == wlast))
                begin
                    pending_reg <= 1'b0;
                end
                if ((row_reg == hlast) && (col_reg == wlast))
                begin
                    pending_reg <= 1'b1;
                end
                if (col_reg == wlast)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == hlast) ? '0 : row_reg + RowW'(1);
                end
                else
                begin
                    col_reg <= col_reg + ColW'(1);
                end
            end
            if (rd_reg)
            begin
                rd_reg <= 1'b0;
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= (ok_reg && crow_reg != '0 && !(crow_reg == hlast
                                  && pending_reg == 1'b0 && 1'b0)) ?
                                 ((crow_reg >= RowW'(1)) ? rd_a_reg : '0) : '0;
                win_reg[1][2] <= ok_reg ? rd_b_reg : '0;
                win_reg[2][2] <= (ok_reg && crow_reg != hlast) ? px_reg : '0;
                second_reg <= !need1_reg;
            end
            if (root_start)
            begin
                root_wait_reg <= 1'b1;
            end
            if (out_load)
            begin
                ovalid_reg    <= 1'b1;
                ored_reg      <= root_r;
                ogrn_reg      <= root_g;
                oblu_reg      <= root_b;
                root_wait_reg <= 1'b0;
                if (!second_reg && need2_reg)
                begin
                    olast_reg  <= 1'b0;
                    oeof_reg   <= 1'b0;
                    second_reg <= 1'b1;
                end
                else
                begin
                    olast_reg <= 1'b1;
                    oeof_reg  <= (crow_reg == hlast) && (second_reg || (c_reg - ColW'(1)
                                 == wlast));
                    need1_reg <= 1'b0;
                    need2_reg <= 1'b0;
                end
            end
        end
    end

    sem_root u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (root_start),
        .sq_r   (sq[0]),
        .sq_g   (sq[1]),
        .sq_b   (sq[2]),
        .ctl    (rctl),
        .root_r (root_r),
        .root_g (root_g),
        .root_b (root_b)
    );

    assign edge_out.valid        = ovalid_reg;
    assign edge_out.red_edge     = ored_reg;
    assign edge_out.green_edge   = ogrn_reg;
    assign edge_out.blue_edge    = oblu_reg;
    assign edge_out.last_of_run  = olast_reg;
    assign edge_out.end_of_frame = oeof_reg;

    a_no_pix_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pix.ready) else $error("pixel taken while busy");
    a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wlast || $past(cfg_acc)) else $error("column past row end");
    a_root_only_busy : assert property (@(posedge clk) disable iff (!rst_n)
        rctl.busy |-> state_reg == ST_ROOT) else $error("root running out of turn");
endmodule
`default_nettype wire
